@@ sv/txc_pkg.sv @@
// ----------------------------------------------------------------------------
// txc_pkg
// Shared types and constants for the text console writer: screen geometry,
// operation codes, cell codes and the controller/datapath command bundles.
// ----------------------------------------------------------------------------
package txc_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Cell codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'd7;

  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_FILL  = ADDR_W'(COLUMNS - 1);

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,  // write character at cursor
    OP_WRITE = 2'd1,  // write cell at position
    OP_READ  = 2'd2,  // read cell at position
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;  // write one reset cell, advance sweep
    logic load;        // capture the incoming word
    logic exec;        // perform the operation, update cursor
    logic fill_step;   // write one blank cell of the scrolled-in row
    logic post;        // load the result register
  } txc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic fill_last;
    logic need_scroll;
    logic out_free;
  } txc_status_t;

endpackage

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: screen store of glyph/attribute cells, cursor
// writes with line wrap and scroll, direct cell writes and cell reads.
// ----------------------------------------------------------------------------
// s_axis: tuser holds the operation (put at cursor, write cell, read cell),
// tdata the glyph, cell colour and column/row. m_axis returns one word per
// input: cursor row/column after the operation, the cell read (zero unless
// reading) and, in tuser, the off-screen position flag. The cfg channel
// writes the text colour for cursor writes and scroll fill; always ready.
// A word goes through capture, store access and result load; the next word
// is accepted only once the result is loaded. A put past the bottom row also
// blanks the new bottom row; the store is a ring of rows, so only the top
// pointer moves. Reset homes the cursor and sets grey on black, then a
// clearing pass writes a blank to each of the CELL_COUNT cells while
// s_axis_tready is low; cfg writes are still taken.
// While m_axis_tready is low the result waits; one more word is accepted and
// worked, then held until the output register frees up.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: text colour
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [txc_pkg::ATTR_W-1:0] cfg_data_i,
  // input words
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // character, cell_colour, column_sel, row_sel
  input  logic [1:0]                 s_axis_tuser,  // operation
  // result words
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // cursor_row, cursor_column, read_entry
  output logic                       m_axis_tuser   // position_error
);
  import txc_pkg::*;

  txc_cmd_t          cmd;
  txc_status_t       status;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;
  logic [CELL_W-1:0] read_entry;

  // Configuration is always taken; it only lands in the colour register.
  assign cfg_ready_o = 1'b1;

  txc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Unpack the input word: lowest field first.
  txc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (s_axis_tuser),
    .character_i      (s_axis_tdata[7:0]),
    .cell_colour_i    (s_axis_tdata[15:8]),
    .column_sel_i     (s_axis_tdata[22:16]),
    .row_sel_i        (s_axis_tdata[27:23]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .cursor_row_o     (cursor_row),
    .cursor_column_o  (cursor_column),
    .read_entry_o     (read_entry),
    .position_error_o (m_axis_tuser)
  );

  // Pack the result word, padded with zeros to 32 bits.
  assign m_axis_tdata = {4'b0000, read_entry, cursor_column, cursor_row};

endmodule

@@ sv/txc_ctrl.sv @@
// ----------------------------------------------------------------------------
// txc_ctrl
// Sequencer for the text console: reset clearing pass, item execution,
// scroll row fill and result hand-off.
// ----------------------------------------------------------------------------
module txc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  txc_pkg::txc_status_t status_i,
  output txc_pkg::txc_cmd_t    cmd_o
);
  import txc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_scroll ? ST_FILL : ST_DONE;
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (status_i.out_free) begin
          cmd_o.post = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ sv/txc_datapath.sv @@
// ----------------------------------------------------------------------------
// txc_datapath
// Screen store, cursor, scroll offset, item registers and result register.
// The store is a ring of rows: top_q names the physical row shown on top.
// ----------------------------------------------------------------------------
module txc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  txc_pkg::txc_cmd_t            cmd_i,
  output txc_pkg::txc_status_t         status_o,
  input  logic                         cfg_valid_i,
  input  logic [txc_pkg::ATTR_W-1:0]   cfg_data_i,
  input  logic [1:0]                   operation_i,
  input  logic [txc_pkg::CHAR_W-1:0]   character_i,
  input  logic [txc_pkg::ATTR_W-1:0]   cell_colour_i,
  input  logic [txc_pkg::COL_W-1:0]    column_sel_i,
  input  logic [txc_pkg::ROW_W-1:0]    row_sel_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [txc_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [txc_pkg::COL_W-1:0]    cursor_column_o,
  output logic [txc_pkg::CELL_W-1:0]   read_entry_o,
  output logic                         position_error_o
);
  import txc_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_q;

  op_e               op_q;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] colour_q;
  logic [COL_W-1:0]  col_sel_q;
  logic [ROW_W-1:0]  row_sel_q;

  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  top_q, top_d;
  logic [ROW_W-1:0]  fill_row_q, fill_row_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [ATTR_W-1:0] text_colour_q;

  logic              out_valid_q;
  logic [ROW_W-1:0]  res_row_q;
  logic [COL_W-1:0]  res_col_q;
  logic [CELL_W-1:0] res_entry_q;
  logic              res_err_q;

  logic              is_newline, wrap, pos_err;
  logic [ROW_W-1:0]  lrow, prow;
  logic [COL_W-1:0]  lcol;
  logic [ROW_W:0]    prow_sum;
  logic [ADDR_W-1:0] cell_addr, fill_addr, mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_we, mem_re;

  // Decode of the captured item
  assign is_newline = (char_q == NEWLINE_CODE);
  assign wrap       = is_newline || (cur_col_q == LAST_COL);
  assign pos_err    = ((op_q == OP_WRITE) || (op_q == OP_READ)) &&
                      ((col_sel_q >= COL_W'(COLUMNS)) || (row_sel_q >= ROW_W'(ROWS)));

  // Logical to physical cell address through the row ring
  assign lrow     = (op_q == OP_PUT) ? cur_row_q : row_sel_q;
  assign lcol     = (op_q == OP_PUT) ? cur_col_q : col_sel_q;
  assign prow_sum = {1'b0, lrow} + {1'b0, top_q};
  assign prow     = (prow_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(prow_sum - (ROW_W+1)'(ROWS))
                                                   : prow_sum[ROW_W-1:0];
  assign cell_addr = ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(lcol);
  assign fill_addr = ADDR_W'(fill_row_q) * ADDR_W'(COLUMNS) + sweep_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = {text_colour_q, char_q};
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_addr  = sweep_q;
      mem_wdata = {RESET_COLOUR, SPACE_CODE};
    end else if (cmd_i.fill_step) begin
      mem_we    = 1'b1;
      mem_addr  = fill_addr;
      mem_wdata = {text_colour_q, SPACE_CODE};
    end else if (cmd_i.exec) begin
      case (op_q)
        OP_PUT: begin
          mem_we = !is_newline;
        end
        OP_WRITE: begin
          mem_we    = !pos_err;
          mem_wdata = {colour_q, char_q};
        end
        OP_READ: begin
          mem_re = !pos_err;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  // Cursor, ring offset and sweep counter
  always_comb begin
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    top_d      = top_q;
    fill_row_d = fill_row_q;
    sweep_d    = sweep_q;
    if (cmd_i.exec && (op_q == OP_PUT)) begin
      if (wrap) begin
        cur_col_d = '0;
        if (cur_row_q == LAST_ROW) begin
          // retire the top row; it becomes the new bottom row
          fill_row_d = top_q;
          top_d      = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
        end else begin
          cur_row_d = cur_row_q + 1'b1;
        end
      end else begin
        cur_col_d = cur_col_q + 1'b1;
      end
    end
    if (cmd_i.clear_step) begin
      sweep_d = (sweep_q == LAST_CELL) ? '0 : sweep_q + 1'b1;
    end else if (cmd_i.fill_step) begin
      sweep_d = (sweep_q == LAST_FILL) ? '0 : sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q     <= '0;
      cur_col_q     <= '0;
      top_q         <= '0;
      fill_row_q    <= '0;
      sweep_q       <= '0;
      text_colour_q <= RESET_COLOUR;
      out_valid_q   <= 1'b0;
    end else begin
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      top_q      <= top_d;
      fill_row_q <= fill_row_d;
      sweep_q    <= sweep_d;
      if (cfg_valid_i) begin
        text_colour_q <= cfg_data_i;
      end
      if (cmd_i.post) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(operation_i);
      char_q    <= character_i;
      colour_q  <= cell_colour_i;
      col_sel_q <= column_sel_i;
      row_sel_q <= row_sel_i;
    end
    if (cmd_i.post) begin
      res_row_q   <= cur_row_q;
      res_col_q   <= cur_col_q;
      res_entry_q <= ((op_q == OP_READ) && !pos_err) ? rd_q : '0;
      res_err_q   <= pos_err;
    end
  end

  assign status_o.clear_last  = (sweep_q == LAST_CELL);
  assign status_o.fill_last   = (sweep_q == LAST_FILL);
  assign status_o.need_scroll = (op_q == OP_PUT) && wrap && (cur_row_q == LAST_ROW);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign cursor_row_o     = res_row_q;
  assign cursor_column_o  = res_col_q;
  assign read_entry_o     = res_entry_q;
  assign position_error_o = res_err_q;

endmodule
